@@ hdl/gfpr_pkg.sv @@
// Shared constants, types and state codes for the GF(2^m) remainder block.
package gfpr_pkg;

	localparam int unsigned SYMBOL_BITS_DEF = 8;
	localparam int unsigned MAX_DEGREE_DEF  = 16;

	// reset values of the two registers
	localparam int unsigned FIELD_POLY_RST = 285;
	localparam int unsigned DEGREE_RST     = 1;

	// register indexes on the APB port (paddr[2])
	localparam logic REG_FIELD_POLY = 1'b0;
	localparam logic REG_DIV_DEGREE = 1'b1;

	// input word kinds
	localparam logic FUNC_LOAD     = 1'b0;
	localparam logic FUNC_DIVIDEND = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_INV   = 4'b0010,
		ST_SCALE = 4'b0100,
		ST_DRAIN = 4'b1000
	} gfpr_state_t;

	// per-cycle commands broadcast along the cell row
	typedef struct packed {
		logic step;   // dividend word: shift in and subtract scaled divisor
		logic scale;  // rescale stored divisor by the leading inverse
		logic drain;  // shift remainder towards cell 0
		logic clear;  // final remainder word taken: zero the window
	} gfpr_ctl_t;

endpackage

@@ hdl/gfpr_mul.sv @@
// GF(2^m) polynomial-basis multiplier, shift-and-add over the bits of b.
module gfpr_mul #(
	parameter int unsigned SYMBOL_BITS = gfpr_pkg::SYMBOL_BITS_DEF
) (
	input  logic [SYMBOL_BITS-1:0] a,
	input  logic [SYMBOL_BITS-1:0] b,
	input  logic [SYMBOL_BITS-1:0] poly,
	output logic [SYMBOL_BITS-1:0] p
);

	always_comb begin
		logic [SYMBOL_BITS-1:0] acc;
		logic                   carry;
		acc = '0;
		for (int k = SYMBOL_BITS - 1; k >= 0; k--) begin
			carry = acc[SYMBOL_BITS-1];
			acc   = acc << 1;
			if (carry) begin
				acc = acc ^ poly;
			end
			if (b[k]) begin
				acc = acc ^ a;
			end
		end
		p = acc;
	end

endmodule

@@ hdl/gfpr_cell.sv @@
// One cell of the remainder row: a window symbol plus its divisor coefficient.
module gfpr_cell #(
	parameter int unsigned SYMBOL_BITS = gfpr_pkg::SYMBOL_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gfpr_pkg::gfpr_ctl_t    ctl,
	input  logic                   active,   // cell lies inside the current degree
	input  logic                   tail,     // last active cell: takes the new word
	input  logic                   load_en,
	input  logic [SYMBOL_BITS-1:0] load_val,
	input  logic [SYMBOL_BITS-1:0] lead,
	input  logic [SYMBOL_BITS-1:0] inv,
	input  logic [SYMBOL_BITS-1:0] poly,
	input  logic [SYMBOL_BITS-1:0] nbr_in,
	input  logic [SYMBOL_BITS-1:0] val_in,
	output logic [SYMBOL_BITS-1:0] win_out
);

	logic [SYMBOL_BITS-1:0] div_q;    // raw divisor coefficient
	logic [SYMBOL_BITS-1:0] q_q;      // coefficient times inverse of leading coeff
	logic [SYMBOL_BITS-1:0] win_q;
	logic [SYMBOL_BITS-1:0] mul_a;
	logic [SYMBOL_BITS-1:0] mul_b;
	logic [SYMBOL_BITS-1:0] prod;
	logic [SYMBOL_BITS-1:0] shift_in;

	// one multiplier, shared between rescaling and the division step
	assign mul_a = ctl.scale ? div_q : q_q;
	assign mul_b = ctl.scale ? inv   : lead;

	gfpr_mul #(.SYMBOL_BITS(SYMBOL_BITS)) u_mul (
		.a    (mul_a),
		.b    (mul_b),
		.poly (poly),
		.p    (prod)
	);

	assign shift_in = tail ? val_in : nbr_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= '0;
			q_q   <= '0;
			win_q <= '0;
		end else begin
			if (load_en) begin
				div_q <= load_val;
			end
			if (ctl.scale) begin
				q_q <= prod;
			end
			if (ctl.clear) begin
				win_q <= '0;
			end else if (ctl.step && active) begin
				win_q <= shift_in ^ prod;
			end else if (ctl.drain && active) begin
				win_q <= tail ? '0 : nbr_in;
			end
		end
	end

	assign win_out = win_q;

endmodule

@@ hdl/gf_poly_remainder.sv @@
// Top level: GF(2^m) polynomial remainder, APB registers, inverse sequencer and cell row.
//
// Computes dividend mod divisor over GF(2^SYMBOL_BITS), as used for Reed-Solomon
// parity. Load words (func 0) write divisor coefficient index (0 = highest degree);
// dividend words (func 1) stream in highest degree first, and the word flagged
// last is followed by divisor_degree result words, highest degree first, with
// position, last_out on the final one and error set if the leading divisor
// coefficient was zero during the run. The window is a row of MAX_DEGREE cells;
// each keeps one window symbol and its divisor coefficient pre-multiplied by the
// inverse of the leading coefficient, so a dividend word needs one GF multiply
// per cell and is taken every cycle while idle with the scaling up to date.
// Load words are also taken every cycle while idle. After a load or a
// field_poly write the inverse is recomputed by a shared multiplier (square,
// multiply, SYMBOL_BITS-1 times) and the cells rescaled: the next dividend word
// waits through ST_INV and ST_SCALE; further loads are still taken while that
// work is pending but not yet begun. After the last word the result is drained
// from cell 0, one word per cycle while out_ready is high, and no input is
// taken until the final result word has gone. divisor_degree is clamped to
// 1..MAX_DEGREE; load indexes above MAX_DEGREE are dropped. Registers:
// field_poly at 0x0, divisor_degree at 0x4.
module gf_poly_remainder #(
	parameter int unsigned SYMBOL_BITS = gfpr_pkg::SYMBOL_BITS_DEF,
	parameter int unsigned MAX_DEGREE  = gfpr_pkg::MAX_DEGREE_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// APB register port
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [2:0]                              paddr,
	input  logic [31:0]                             pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready,
	// input words
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    func,
	input  logic [$clog2(MAX_DEGREE+1)-1:0]         index,
	input  logic [SYMBOL_BITS-1:0]                  value,
	input  logic                                    last,
	// result words
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [SYMBOL_BITS-1:0]                  coeff,
	output logic [((MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1)-1:0] position,
	output logic                                    last_out,
	output logic                                    error
);

	localparam int unsigned IDX_W     = $clog2(MAX_DEGREE + 1);
	localparam int unsigned DEG_W     = $clog2(MAX_DEGREE + 1);
	localparam int unsigned POS_W     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int unsigned FP_W      = SYMBOL_BITS + 1;
	localparam int unsigned INV_STEPS = 2 * (SYMBOL_BITS - 1);
	localparam int unsigned STEP_W    = (INV_STEPS > 1) ? $clog2(INV_STEPS) : 1;

	// ---------------------------------------------------------------- registers
	logic [FP_W-1:0]  fp_q;
	logic [DEG_W-1:0] deg_q;
	logic             cfg_wr;
	logic             fp_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign fp_wr  = cfg_wr && (paddr[2] == gfpr_pkg::REG_FIELD_POLY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q  <= FP_W'(gfpr_pkg::FIELD_POLY_RST);
			deg_q <= DEG_W'(gfpr_pkg::DEGREE_RST);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				gfpr_pkg::REG_FIELD_POLY: fp_q  <= pwdata[FP_W-1:0];
				gfpr_pkg::REG_DIV_DEGREE: deg_q <= pwdata[DEG_W-1:0];
				default:                  fp_q  <= fp_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			gfpr_pkg::REG_FIELD_POLY: prdata = 32'(fp_q);
			gfpr_pkg::REG_DIV_DEGREE: prdata = 32'(deg_q);
			default:                  prdata = '0;
		endcase
	end

	// effective degree, clamped to 1..MAX_DEGREE
	logic [DEG_W-1:0] d_eff;
	always_comb begin
		priority if (deg_q == '0) begin
			d_eff = DEG_W'(1);
		end else if (deg_q > DEG_W'(MAX_DEGREE)) begin
			d_eff = DEG_W'(MAX_DEGREE);
		end else begin
			d_eff = deg_q;
		end
	end

	logic [SYMBOL_BITS-1:0] poly;
	assign poly = fp_q[SYMBOL_BITS-1:0];   // top bit is implied

	// ---------------------------------------------------------------- control
	gfpr_pkg::gfpr_state_t state_q;
	logic [STEP_W-1:0]      step_q;
	logic [POS_W-1:0]       pos_q;
	logic                   dirty_q;   // inverse / scaled divisor out of date
	logic                   err_q;
	logic [SYMBOL_BITS-1:0] div0_q;    // leading divisor coefficient
	logic [SYMBOL_BITS-1:0] sq_q;
	logic [SYMBOL_BITS-1:0] res_q;     // inverse of div0 once done

	logic in_fire, out_fire, load_fire, div_fire, start_inv, final_word;
	logic [SYMBOL_BITS-1:0] inv_a, inv_p;
	logic [SYMBOL_BITS-1:0] win [MAX_DEGREE];

	// a dividend word waits while the scaled divisor is stale
	assign in_ready  = (state_q == gfpr_pkg::ST_IDLE)
	                   && !(dirty_q && (func == gfpr_pkg::FUNC_DIVIDEND));
	assign in_fire   = in_valid && in_ready;
	assign load_fire = in_fire && (func == gfpr_pkg::FUNC_LOAD)
	                   && (index <= IDX_W'(MAX_DEGREE));
	assign div_fire  = in_fire && (func == gfpr_pkg::FUNC_DIVIDEND);
	assign start_inv = (state_q == gfpr_pkg::ST_IDLE) && dirty_q
	                   && !(in_valid && (func == gfpr_pkg::FUNC_LOAD));

	assign out_valid  = (state_q == gfpr_pkg::ST_DRAIN);
	assign out_fire   = out_valid && out_ready;
	assign last_out   = (DEG_W'(pos_q) == (d_eff - DEG_W'(1)));
	assign final_word = out_fire && last_out;
	assign coeff      = win[0];
	assign position   = pos_q;
	assign error      = err_q;

	// shared multiplier of the inverse sequencer: even steps square, odd steps accumulate
	assign inv_a = step_q[0] ? res_q : sq_q;

	gfpr_mul #(.SYMBOL_BITS(SYMBOL_BITS)) u_inv_mul (
		.a    (inv_a),
		.b    (sq_q),
		.poly (poly),
		.p    (inv_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gfpr_pkg::ST_IDLE;
			step_q  <= '0;
			pos_q   <= '0;
			dirty_q <= 1'b0;
			err_q   <= 1'b0;
			div0_q  <= '0;
			sq_q    <= '0;
			res_q   <= '0;
		end else begin
			if (load_fire && (index == '0)) begin
				div0_q <= value;
			end
			if (load_fire || fp_wr) begin
				dirty_q <= 1'b1;
			end else if (start_inv) begin
				dirty_q <= 1'b0;
			end
			if (div_fire && (div0_q == '0)) begin
				err_q <= 1'b1;
			end else if (final_word) begin
				err_q <= 1'b0;
			end
			unique case (state_q)
				gfpr_pkg::ST_IDLE: begin
					if (div_fire && last) begin
						pos_q   <= '0;
						state_q <= gfpr_pkg::ST_DRAIN;
					end else if (start_inv) begin
						sq_q    <= div0_q;
						res_q   <= SYMBOL_BITS'(1);
						step_q  <= '0;
						state_q <= gfpr_pkg::ST_INV;
					end
				end
				gfpr_pkg::ST_INV: begin
					if (step_q[0]) begin
						res_q <= inv_p;
					end else begin
						sq_q <= inv_p;
					end
					if (step_q == STEP_W'(INV_STEPS - 1)) begin
						state_q <= gfpr_pkg::ST_SCALE;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				gfpr_pkg::ST_SCALE: begin
					state_q <= gfpr_pkg::ST_IDLE;
				end
				gfpr_pkg::ST_DRAIN: begin
					if (final_word) begin
						state_q <= gfpr_pkg::ST_IDLE;
					end else if (out_fire) begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
				default: begin
					state_q <= gfpr_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- cell row
	gfpr_pkg::gfpr_ctl_t ctl;
	assign ctl.step  = div_fire;
	assign ctl.scale = (state_q == gfpr_pkg::ST_SCALE);
	assign ctl.drain = out_fire && !last_out;
	assign ctl.clear = final_word;

	for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_cell
		localparam logic [DEG_W-1:0] CELL_J = DEG_W'(j);
		logic                   act;
		logic                   tl;
		logic                   ld;
		logic [SYMBOL_BITS-1:0] nbr;

		assign act = (CELL_J < d_eff);
		assign tl  = (CELL_J == (d_eff - DEG_W'(1)));
		assign ld  = load_fire && (index == IDX_W'(j + 1));

		if (j == MAX_DEGREE - 1) begin : g_end
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = win[j+1];
		end

		gfpr_cell #(.SYMBOL_BITS(SYMBOL_BITS)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.active   (act),
			.tail     (tl),
			.load_en  (ld),
			.load_val (value),
			.lead     (win[0]),
			.inv      (res_q),
			.poly     (poly),
			.nbr_in   (nbr),
			.val_in   (value),
			.win_out  (win[j])
		);
	end

`ifndef SYNTHESIS
	// a dividend word never meets a stale scaled divisor
	a_no_stale_step: assert property (@(posedge clk) disable iff (!arst_n)
		div_fire |-> !dirty_q && (state_q == gfpr_pkg::ST_IDLE))
		else $error("dividend word taken with stale divisor scaling");

	// the last dividend word starts a run of results at position zero
	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(div_fire && last) |=> out_valid && (position == '0))
		else $error("result run did not start after last word");

	// the window is empty once the final result word has gone
	a_clear_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		final_word |=> (win[0] == '0) && !err_q && !out_valid)
		else $error("window or error flag not cleared after run");

	// the error flag holds for the whole run of results
	a_err_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !final_word) |=> $stable(error))
		else $error("error flag changed within a result run");
`endif

endmodule
